>>> src/kpm_pkg.sv
// kpm_pkg: shared types, constants and the button key table of the keyboard-to-pad mapper
// no dependencies; used by every module in src
package kpm_pkg;

    localparam int RING_DEPTH      = 32;
    localparam int RING_IDX_W      = $clog2(RING_DEPTH);
    localparam int BUTTON_COUNT    = 12;
    localparam int BTN_W           = 4;
    localparam int KEYS_PER_BUTTON = 3;
    localparam int KEY_IDX_W       = 8;
    localparam int KEY_COUNT       = 256;

    typedef logic [BUTTON_COUNT-1:0] t_mask;
    typedef logic [KEY_IDX_W-1:0]    t_key_idx;

    typedef enum logic [2:0] {
        OP_KEY   = 3'd0,
        OP_FEED  = 3'd1,
        OP_POLL  = 3'd2,
        OP_POP   = 3'd3,
        OP_CLEAR = 3'd4
    } t_op;

    // key store index: bit 7 marks the extended prefix, zero marks an empty slot
    localparam t_key_idx KEY_ROM [BUTTON_COUNT][KEYS_PER_BUTTON] = '{
        '{8'hC8, 8'h11, 8'h00},   // up
        '{8'hD0, 8'h1F, 8'h00},   // down
        '{8'hCB, 8'h00, 8'h00},   // left
        '{8'hCD, 8'h00, 8'h00},   // right
        '{8'h1D, 8'h2D, 8'h00},   // a
        '{8'h39, 8'h2C, 8'h00},   // b
        '{8'h2E, 8'h00, 8'h00},   // x
        '{8'h2F, 8'h32, 8'h00},   // y
        '{8'h1E, 8'h10, 8'h00},   // l
        '{8'h20, 8'h12, 8'h00},   // r
        '{8'h1C, 8'h00, 8'h00},   // start
        '{8'h01, 8'h0F, 8'h00}    // select
    };

    typedef struct packed {
        logic             hit;
        logic [BTN_W-1:0] btn;
        logic             level;
    } t_key_hit;

    typedef struct packed {
        logic [BTN_W-1:0] btn;
        logic             down;
    } t_event;

    typedef struct packed {
        logic   push;
        logic   pop;
        logic   clear;
        t_event ev;
    } t_ring_req;

    typedef struct packed {
        logic   valid;
        t_event ev;
    } t_ring_rsp;

endpackage

>>> src/kpm_key_map.sv
// kpm_key_map: held-key store and the per-button level of the key just written
// depends on kpm_pkg
module kpm_key_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic              i_clear,
    input  kpm_pkg::t_key_idx i_idx,
    input  logic              i_released,
    output kpm_pkg::t_key_hit o_hit
);

    logic [kpm_pkg::KEY_COUNT-1:0] r_keys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_keys <= '0;
        end else if (i_we) begin
            r_keys[i_idx] <= ~i_released;
        end
    end

    // level of the matching button, seen with the new key state
    always_comb begin
        kpm_pkg::t_key_idx m;
        logic              lvl;
        o_hit = '0;
        for (int b = 0; b < kpm_pkg::BUTTON_COUNT; b++) begin
            lvl = 1'b0;
            for (int i = 0; i < kpm_pkg::KEYS_PER_BUTTON; i++) begin
                m = kpm_pkg::KEY_ROM[b][i];
                if (m != '0) begin
                    if (m == i_idx) begin
                        lvl = lvl | ~i_released;
                    end else begin
                        lvl = lvl | r_keys[m];
                    end
                end
            end
            for (int i = 0; i < kpm_pkg::KEYS_PER_BUTTON; i++) begin
                if (kpm_pkg::KEY_ROM[b][i] != '0 && kpm_pkg::KEY_ROM[b][i] == i_idx) begin
                    o_hit.hit   = 1'b1;
                    o_hit.btn   = kpm_pkg::BTN_W'(b);
                    o_hit.level = lvl;
                end
            end
        end
    end

endmodule

>>> src/kpm_ring.sv
// kpm_ring: button event ring with read and write indexes, one slot kept free
// depends on kpm_pkg
module kpm_ring (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kpm_pkg::t_ring_req i_req,
    output kpm_pkg::t_ring_rsp o_rsp
);

    kpm_pkg::t_event                r_ring [kpm_pkg::RING_DEPTH];
    logic [kpm_pkg::RING_IDX_W-1:0] r_wr;
    logic [kpm_pkg::RING_IDX_W-1:0] r_rd;
    logic [kpm_pkg::RING_IDX_W-1:0] n_wr;
    logic [kpm_pkg::RING_IDX_W-1:0] n_rd;
    logic [kpm_pkg::RING_IDX_W-1:0] wr_next;
    logic [kpm_pkg::RING_IDX_W-1:0] rd_next;
    logic                           can_push;
    logic                           not_empty;

    localparam logic [kpm_pkg::RING_IDX_W-1:0] LAST_IDX =
        kpm_pkg::RING_IDX_W'(kpm_pkg::RING_DEPTH - 1);

    always_comb begin
        wr_next   = (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
        rd_next   = (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
        can_push  = i_req.push && (wr_next != r_rd);
        not_empty = (r_rd != r_wr);
        n_wr      = can_push ? wr_next : r_wr;
        n_rd      = (i_req.pop && not_empty) ? rd_next : r_rd;
        o_rsp.valid = i_req.pop && not_empty;
        o_rsp.ev    = o_rsp.valid ? r_ring[r_rd] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_push) begin
            r_ring[r_wr] <= i_req.ev;
        end
    end

endmodule

>>> src/keyboard_to_pad_mapper.sv
// keyboard_to_pad_mapper: key events and button feeds to a virtual pad with poll and event ring
// depends on kpm_pkg, kpm_key_map, kpm_ring
//
//  channel   dir  handshake              payload
//  s         in   i_s_tvalid/o_s_tready  i_s_tdata, i_s_tuser (op)
//  m         out  o_m_tvalid/i_m_tready  o_m_tdata
//  cfg       in   i_cfg_we               i_cfg_wdata (game_owns_pad)
//
// one item per cycle unless the result side stalls; each item passes through the
// input register, then table lookup and mask logic, then the result register
// a stalled result holds the input register, which holds the input side
// reset clears all state; the clear op does the same but keeps game_owns_pad
module keyboard_to_pad_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // scan_code[6:0], extended, released, button[3:0], press
    input  logic [2:0]  i_s_tuser,   // op[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // consumed, held_mask, latched_mask, edge_mask,
                                     // event_valid, event_button[3:0], event_down
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    logic                      r_game_owns_pad;
    logic                      r_in_valid;
    kpm_pkg::t_op              r_op;
    logic [6:0]                r_scan_code;
    logic                      r_extended;
    logic                      r_released;
    logic [kpm_pkg::BTN_W-1:0] r_button;
    logic                      r_press;

    kpm_pkg::t_mask r_held, n_held;
    kpm_pkg::t_mask r_latched, n_latched;
    kpm_pkg::t_mask r_edge, n_edge;
    kpm_pkg::t_mask r_acc, n_acc;

    logic        r_out_valid;
    logic [47:0] r_out_data;

    logic                      out_free;
    logic                      fire;
    logic                      key_we;
    logic                      clear;
    kpm_pkg::t_key_hit         hit;
    kpm_pkg::t_ring_req        ring_req;
    kpm_pkg::t_ring_rsp        ring_rsp;
    logic                      req_valid;
    logic [kpm_pkg::BTN_W-1:0] req_btn;
    logic                      req_level;
    kpm_pkg::t_mask            bit_sel;
    logic                      change;
    logic                      consumed;

    assign out_free   = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign key_we     = fire && (r_op == kpm_pkg::OP_KEY);
    assign clear      = fire && (r_op == kpm_pkg::OP_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_game_owns_pad <= 1'b0;
        end else if (i_cfg_we) begin
            r_game_owns_pad <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_op        <= kpm_pkg::t_op'(i_s_tuser);
            r_scan_code <= i_s_tdata[6:0];
            r_extended  <= i_s_tdata[7];
            r_released  <= i_s_tdata[8];
            r_button    <= i_s_tdata[12:9];
            r_press     <= i_s_tdata[13];
        end
    end

    kpm_key_map u_key_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (key_we),
        .i_clear    (clear),
        .i_idx      ({r_extended, r_scan_code}),
        .i_released (r_released),
        .o_hit      (hit)
    );

    // button level request shared by key events and feeds
    always_comb begin
        req_valid = 1'b0;
        req_btn   = '0;
        req_level = 1'b0;
        case (r_op)
            kpm_pkg::OP_KEY: begin
                req_valid = hit.hit;
                req_btn   = hit.btn;
                req_level = hit.level;
            end
            kpm_pkg::OP_FEED: begin
                req_valid = ({1'b0, r_button} < (kpm_pkg::BTN_W + 1)'(kpm_pkg::BUTTON_COUNT));
                req_btn   = r_button;
                req_level = r_press;
            end
            default: begin
                req_valid = 1'b0;
            end
        endcase
        bit_sel = kpm_pkg::t_mask'(1) << req_btn;
        change  = fire && req_valid && (req_level != ((r_held & bit_sel) != '0));
    end

    always_comb begin
        n_held    = r_held;
        n_latched = r_latched;
        n_edge    = r_edge;
        n_acc     = r_acc;
        if (change) begin
            if (req_level) begin
                n_held = r_held | bit_sel;
                n_acc  = r_acc | bit_sel;
            end else begin
                n_held = r_held & ~bit_sel;
            end
        end
        if (fire) begin
            case (r_op)
                kpm_pkg::OP_POLL: begin
                    n_edge    = r_acc;
                    n_acc     = '0;
                    n_latched = r_held;
                end
                kpm_pkg::OP_CLEAR: begin
                    n_held    = '0;
                    n_latched = '0;
                    n_edge    = '0;
                    n_acc     = '0;
                end
                default: begin
                    n_edge = n_edge;
                end
            endcase
        end
    end

    always_comb begin
        ring_req.push   = change;
        ring_req.pop    = fire && (r_op == kpm_pkg::OP_POP);
        ring_req.clear  = clear;
        ring_req.ev.btn = req_btn;
        ring_req.ev.down = req_level;
    end

    kpm_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ring_req),
        .o_rsp   (ring_rsp)
    );

    assign consumed = (r_op == kpm_pkg::OP_KEY) && r_game_owns_pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_latched <= '0;
            r_edge    <= '0;
            r_acc     <= '0;
        end else begin
            r_held    <= n_held;
            r_latched <= n_latched;
            r_edge    <= n_edge;
            r_acc     <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {5'b0, ring_rsp.ev.down, ring_rsp.ev.btn, ring_rsp.valid,
                           n_edge, n_latched, n_held, consumed};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> tb/kpm_pad_checker.sv
// kpm_pad_checker: watches the item, result and config channels of keyboard_to_pad_mapper,
// predicts every result and compares it with what the block returns
// depends on kpm_pkg
module kpm_pad_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // scan_code[6:0], extended, released, button[3:0], press
    input  logic [2:0]  i_s_tuser,   // op[2:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,   // consumed, held_mask, latched_mask, edge_mask,
                                     // event_valid, event_button[3:0], event_down
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output int          o_mismatches,
    output int          o_reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      ev_down;
        logic [kpm_pkg::BTN_W-1:0] ev_btn;
        logic                      ev_valid;
        kpm_pkg::t_mask            edges;
        kpm_pkg::t_mask            latched;
        kpm_pkg::t_mask            held;
        logic                      consumed;
    } t_pad_report;

    // bit 8 marks the extended prefix, zero ends the list
    localparam logic [8:0] PAD_KEYS [kpm_pkg::BUTTON_COUNT][kpm_pkg::KEYS_PER_BUTTON] = '{
        '{9'h148, 9'h011, 9'h000},
        '{9'h150, 9'h01F, 9'h000},
        '{9'h14B, 9'h000, 9'h000},
        '{9'h14D, 9'h000, 9'h000},
        '{9'h01D, 9'h02D, 9'h000},
        '{9'h039, 9'h02C, 9'h000},
        '{9'h02E, 9'h000, 9'h000},
        '{9'h02F, 9'h032, 9'h000},
        '{9'h01E, 9'h010, 9'h000},
        '{9'h020, 9'h012, 9'h000},
        '{9'h01C, 9'h000, 9'h000},
        '{9'h001, 9'h00F, 9'h000}
    };

    logic [kpm_pkg::KEY_COUNT-1:0] key_down = '0;
    kpm_pkg::t_mask                held     = '0;
    kpm_pkg::t_mask                latched  = '0;
    kpm_pkg::t_mask                edges    = '0;
    kpm_pkg::t_mask                rise_acc = '0;
    logic                          owns_pad = 1'b0;
    logic [4:0]                    pad_events [$];
    t_pad_report                   reports_due [$];
    int                            mismatch_count = 0;

    function automatic void clear_pad();
        key_down = '0;
        held     = '0;
        latched  = '0;
        edges    = '0;
        rise_acc = '0;
        pad_events.delete();
    endfunction

    function automatic logic button_level(int b);
        for (int s = 0; s < kpm_pkg::KEYS_PER_BUTTON; s++) begin
            if (PAD_KEYS[b][s] == '0) break;
            if (key_down[{PAD_KEYS[b][s][8], PAD_KEYS[b][s][6:0]}]) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void move_button(int b, logic down);
        if (held[b] == down) return;
        held[b] = down;
        if (down) rise_acc[b] = 1'b1;
        // one slot stays free, so a full ring drops the new event
        if (pad_events.size() < kpm_pkg::RING_DEPTH - 1)
            pad_events.push_back({down, kpm_pkg::BTN_W'(b)});
    endfunction

    function automatic t_pad_report predict_pad(logic [2:0] op, logic [15:0] d);
        t_pad_report r;
        logic [8:0]  key;
        logic [4:0]  ev;
        r = '0;
        case (op)
            kpm_pkg::OP_KEY: begin
                key = {d[7], 1'b0, d[6:0]};
                key_down[{d[7], d[6:0]}] = ~d[8];
                for (int b = 0; b < kpm_pkg::BUTTON_COUNT; b++) begin
                    for (int s = 0; s < kpm_pkg::KEYS_PER_BUTTON; s++) begin
                        if (PAD_KEYS[b][s] == '0) break;
                        if (PAD_KEYS[b][s] == key) begin
                            move_button(b, button_level(b));
                            break;
                        end
                    end
                end
                r.consumed = owns_pad;
            end
            kpm_pkg::OP_FEED: begin
                if (d[12:9] < kpm_pkg::BUTTON_COUNT) move_button(int'(d[12:9]), d[13]);
            end
            kpm_pkg::OP_POLL: begin
                edges    = rise_acc;
                rise_acc = '0;
                latched  = held;
            end
            kpm_pkg::OP_POP: begin
                if (pad_events.size() != 0) begin
                    ev         = pad_events.pop_front();
                    r.ev_valid = 1'b1;
                    r.ev_btn   = ev[3:0];
                    r.ev_down  = ev[4];
                end
            end
            kpm_pkg::OP_CLEAR: clear_pad();
            default: ;
        endcase
        r.held    = held;
        r.latched = latched;
        r.edges   = edges;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pad_report want;
        t_pad_report got;
        if (!i_rst_n) begin
            clear_pad();
            owns_pad = 1'b0;
            reports_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_pad_report'(i_m_tdata[42:0]);
                if (reports_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %012h", i_m_tdata);
                end else begin
                    want = reports_due.pop_front();
                    if (got !== want || i_m_tdata[47:43] !== '0) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: want consumed=%0d held=%03h latched=%03h ",
                                      "edges=%03h ev=%0d/%0d/%0d, got consumed=%0d held=%03h ",
                                      "latched=%03h edges=%03h ev=%0d/%0d/%0d pad=%02h"},
                                     want.consumed, want.held, want.latched, want.edges,
                                     want.ev_valid, want.ev_btn, want.ev_down,
                                     got.consumed, got.held, got.latched, got.edges,
                                     got.ev_valid, got.ev_btn, got.ev_down, i_m_tdata[47:43]);
                    end
                end
            end
            if (i_cfg_we) owns_pad = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready)
                reports_due.push_back(predict_pad(i_s_tuser, i_s_tdata));
        end
        o_mismatches  <= mismatch_count;
        o_reports_due <= reports_due.size();
    end

endmodule

>>> tb/keyboard_to_pad_mapper_tb.sv
// keyboard_to_pad_mapper_tb: drives key events, button feeds, polls, pops and clears into
// keyboard_to_pad_mapper with random stalls on both sides and prints the verdict
// depends on kpm_pkg, keyboard_to_pad_mapper and kpm_pad_checker
module keyboard_to_pad_mapper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         SEGMENT_ITEMS = 258;
    localparam int         BURST_ITEMS   = 80;
    localparam logic [2:0] OP_SPARE_MAX  = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic [2:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic        i_cfg_we;
    logic        i_cfg_wdata;

    int mismatches;
    int reports_due;
    int cycle_count    = 0;
    int src_idle_pct   = 35;
    int sink_stall_pct = 68;

    keyboard_to_pad_mapper u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    kpm_pad_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_reports_due (reports_due)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [15:0] item_bits(logic [6:0] scan, logic ext, logic rel,
                                              logic [3:0] btn, logic press);
        return {2'b00, press, btn, rel, ext, scan};
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [15:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (reports_due != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_owns_pad(input logic value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_item(input int pop_pct);
        int                r;
        int                b;
        kpm_pkg::t_key_idx key;
        logic [2:0]        op;
        logic [15:0]       data;
        r    = $urandom_range(99);
        data = {2'b00, 14'($urandom)};
        if (r < pop_pct) begin
            op = kpm_pkg::OP_POP;
        end else if (r < pop_pct + 6) begin
            op = kpm_pkg::OP_POLL;
        end else if (r < pop_pct + 8) begin
            op = ($urandom_range(9) == 0) ? kpm_pkg::OP_CLEAR
                 : 3'($urandom_range(kpm_pkg::OP_CLEAR + 1, OP_SPARE_MAX));
        end else if (r < pop_pct + 40) begin
            op = kpm_pkg::OP_FEED;
            if ($urandom_range(7) != 0)
                data[12:9] = 4'($urandom_range(kpm_pkg::BUTTON_COUNT - 1));
        end else begin
            op = kpm_pkg::OP_KEY;
            // mostly mapped keys so that buttons really move
            if ($urandom_range(4) != 0) begin
                b   = $urandom_range(kpm_pkg::BUTTON_COUNT - 1);
                key = kpm_pkg::KEY_ROM[b][$urandom_range(1)];
                if (key == '0) key = kpm_pkg::KEY_ROM[b][0];
                data[7:0] = key;
            end
        end
        send_item(op, data);
    endtask

    initial begin
        int pop_pct;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= kpm_pkg::OP_KEY;
        i_m_tready  <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_owns_pad(1'b0);

        send_item(kpm_pkg::OP_CLEAR, '0);
        send_item(kpm_pkg::OP_KEY,  item_bits(7'h48, 1'b1, 1'b0, 4'd0, 1'b0));
        send_item(kpm_pkg::OP_KEY,  item_bits(7'h11, 1'b0, 1'b0, 4'd0, 1'b0));
        send_item(kpm_pkg::OP_KEY,  item_bits(7'h48, 1'b1, 1'b1, 4'd0, 1'b0));
        send_item(kpm_pkg::OP_KEY,  item_bits(7'h11, 1'b0, 1'b1, 4'd0, 1'b0));
        send_item(kpm_pkg::OP_KEY,  item_bits(7'h00, 1'b0, 1'b0, 4'd0, 1'b0));
        send_item(kpm_pkg::OP_KEY,  item_bits(7'h00, 1'b1, 1'b0, 4'd0, 1'b0));
        send_item(kpm_pkg::OP_KEY,  item_bits(7'h7F, 1'b1, 1'b0, 4'hF, 1'b1));
        send_item(kpm_pkg::OP_KEY,  item_bits(7'h7F, 1'b1, 1'b1, 4'hF, 1'b1));
        send_item(kpm_pkg::OP_FEED, item_bits(7'h7F, 1'b1, 1'b1, 4'd15, 1'b1));
        send_item(kpm_pkg::OP_FEED, item_bits(7'h00, 1'b0, 1'b0, 4'd12, 1'b1));
        send_item(kpm_pkg::OP_FEED, item_bits(7'h00, 1'b0, 1'b0, 4'd11, 1'b1));
        send_item(kpm_pkg::OP_FEED, item_bits(7'h00, 1'b0, 1'b0, 4'd11, 1'b1));
        send_item(kpm_pkg::OP_FEED, item_bits(7'h00, 1'b0, 1'b0, 4'd0, 1'b0));
        send_item(kpm_pkg::OP_POLL, '0);
        send_item(kpm_pkg::OP_KEY,  item_bits(7'h1D, 1'b0, 1'b0, 4'd0, 1'b0));
        send_item(kpm_pkg::OP_POLL, '1);
        repeat (5) send_item(kpm_pkg::OP_POP, '0);
        for (int op = kpm_pkg::OP_CLEAR + 1; op <= OP_SPARE_MAX; op++) send_item(3'(op), '1);
        send_item(kpm_pkg::OP_CLEAR, '0);

        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                src_idle_pct   = 68;
                sink_stall_pct = 35;
            end else if (seg == 4) begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            write_owns_pad((seg % 2) == 0);
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                // bursts with few pops let the event ring fill up
                if (n % BURST_ITEMS == 0)
                    pop_pct = ((n / BURST_ITEMS) % 2 == 0) ? 1 : $urandom_range(5, 40);
                random_item(pop_pct);
            end
        end

        drain_results();
        if (mismatches == 0 && reports_due == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
